### src/tsmd_pkg.sv
// Shared types, constants and distance helpers for the two-server minimum distance block.
// Used by tsmd_relax and two_server_min_distance_dp; depends on nothing else.
package tsmd_pkg;

    localparam int MAX_EVENTS  = 1024;
    localparam int MAX_COORD   = 1023;
    localparam int STORE_DEPTH = MAX_EVENTS + 2;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(MAX_EVENTS + 1);
    localparam int COORD_W     = 10;
    localparam int DIST_W      = COORD_W + 1;
    localparam int COST_W      = 22;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam logic [COST_W-1:0]  COST_MAX  = {COST_W{1'b1}};
    localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(MAX_COORD);

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } point_t;

    // Write request into the cost table.
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [COST_W-1:0] data;
    } cost_wr_t;

    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
        return (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [DIST_W-1:0] manhattan(input point_t a, input point_t b);
        return DIST_W'(abs_diff(a.row, b.row)) + DIST_W'(abs_diff(a.col, b.col));
    endfunction

    // The addend is far below the cost range, so the sum overflows by at most one bit.
    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [DIST_W-1:0] b);
        logic [COST_W:0] sum;
        sum = {1'b0, a} + (COST_W + 1)'(b);
        return sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
    endfunction

endpackage

### src/tsmd_relax.sv
// Two-stage relaxation datapath: updates one cost entry per cycle and tracks the minima.
// Depends on tsmd_pkg.
module tsmd_relax (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clear,
    input  logic                      in_vld,
    input  logic [tsmd_pkg::IDX_W-1:0]  in_idx,
    input  tsmd_pkg::point_t            pos_q,
    input  logic [tsmd_pkg::COST_W-1:0] cost_q,
    input  tsmd_pkg::point_t            new_pos,
    input  logic [tsmd_pkg::DIST_W-1:0] d_move,
    output tsmd_pkg::cost_wr_t          cost_wr,
    output logic [tsmd_pkg::COST_W-1:0] joined,
    output logic [tsmd_pkg::COST_W-1:0] best_run,
    output logic                      busy
);
    import tsmd_pkg::*;

    logic              s2_vld_reg;
    logic [DIST_W-1:0] s2_dist_reg;
    logic [COST_W-1:0] s2_cost_reg;
    logic [COST_W-1:0] s2_upd_reg;
    logic [COST_W-1:0] joined_reg;
    logic [COST_W-1:0] best_reg;
    logic [COST_W-1:0] upd;
    logic [COST_W-1:0] via;

    // Stage one: the server at the latest position moves; entry j keeps its other server.
    assign upd          = sat_add(cost_q, d_move);
    assign cost_wr.en   = in_vld;
    assign cost_wr.idx  = in_idx;
    assign cost_wr.data = upd;

    // Stage two: the server at position j moves instead, which frees the latest position.
    assign via = sat_add(s2_cost_reg, s2_dist_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_dist_reg <= manhattan(pos_q, new_pos);
        s2_cost_reg <= cost_q;
        s2_upd_reg  <= upd;
        if (clear)
        begin
            joined_reg <= COST_MAX;
            best_reg   <= COST_MAX;
        end
        else if (s2_vld_reg)
        begin
            if (via < joined_reg)
            begin
                joined_reg <= via;
            end
            if (s2_upd_reg < best_reg)
            begin
                best_reg <= s2_upd_reg;
            end
        end
    end

    assign joined   = joined_reg;
    assign best_run = best_reg;
    assign busy     = s2_vld_reg;

endmodule

### src/two_server_min_distance_dp.sv
// Top level of the two-server minimum distance block: handshakes, sequencer and memories.
// Depends on tsmd_pkg and tsmd_relax.
//
// Each incident request walks the cost table once through one read address shared by the
// position store and the cost table, one entry per cycle. With k incidents already in the
// sequence, the walk covers k + 1 entries. A request passes S_PREP, S_WALK, S_DRAIN and
// S_DONE, after S_SEED0 and S_SEED1 when it starts a new sequence; one dropped because the
// store is full goes straight to S_DONE. One request is worked on at a time; a finished result
// waits in the output register while the next request is taken. Both memories start undefined
// and need no clearing pass: entries are written before they are read within each sequence.
module two_server_min_distance_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tsmd_pkg::IN_TDATA_W-1:0]   s_tdata,  // row [9:0], col [19:10], zero fill
    input  logic                              s_tuser,  // new_problem [0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tsmd_pkg::OUT_TDATA_W-1:0]  m_tdata,  // best_total [21:0], zero fill
    output logic                              m_tuser,  // dropped [0]
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tsmd_pkg::COORD_W-1:0]      cfg_data  // grid_size [9:0]
);
    import tsmd_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SEED0 = 3'd1;
    localparam logic [2:0] S_SEED1 = 3'd2;
    localparam logic [2:0] S_PREP  = 3'd3;
    localparam logic [2:0] S_WALK  = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam logic [IDX_W-1:0] IDX_FIRST  = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_SECOND = IDX_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(MAX_EVENTS);

    point_t            pos_mem [STORE_DEPTH];
    logic [COST_W-1:0] cost_mem [STORE_DEPTH];

    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [COORD_W-1:0] grid_reg;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic               drop_reg, drop_next;
    point_t             in_pos_reg, in_pos_next;
    point_t             last_pos_reg, last_pos_next;
    logic [DIST_W-1:0]  d_move_reg, d_move_next;
    logic [COST_W-1:0]  best_hold_reg, best_hold_next;
    logic               out_valid_reg, out_valid_next;
    logic [COST_W-1:0]  out_best_reg, out_best_next;
    logic               out_drop_reg, out_drop_next;

    logic               rd_en;
    logic [IDX_W-1:0]   rd_idx;
    logic               rd_vld_reg;
    logic [IDX_W-1:0]   rd_idx_q_reg;
    point_t             pos_q;
    logic [COST_W-1:0]  cost_q;

    logic               pos_we;
    logic [IDX_W-1:0]   pos_wa;
    point_t             pos_wd;
    cost_wr_t           fsm_wr;
    cost_wr_t           relax_wr;
    cost_wr_t           cost_wr;

    logic               relax_clear;
    logic [COST_W-1:0]  joined;
    logic [COST_W-1:0]  best_run;
    logic [COST_W-1:0]  final_best;
    logic               relax_busy;
    logic               out_free;
    logic               start_seq;
    logic [IDX_W-1:0]   last_idx;
    point_t             in_pos;
    point_t             grid_pos;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = OUT_TDATA_W'(out_best_reg);
    assign m_tuser   = out_drop_reg;

    assign in_pos.row   = clamp_coord(s_tdata[COORD_W-1:0]);
    assign in_pos.col   = clamp_coord(s_tdata[2*COORD_W-1:COORD_W]);
    assign grid_pos.row = clamp_coord(grid_reg);
    assign grid_pos.col = clamp_coord(grid_reg);

    assign start_seq  = s_tuser || (count_reg == '0);
    assign last_idx   = IDX_W'(count_reg) + IDX_W'(1);
    assign out_free   = !out_valid_reg || m_tready;
    assign final_best = (joined < best_run) ? joined : best_run;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        j_next         = j_reg;
        drop_next      = drop_reg;
        in_pos_next    = in_pos_reg;
        last_pos_next  = last_pos_reg;
        d_move_next    = d_move_reg;
        best_hold_next = best_hold_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_best_next  = out_best_reg;
        out_drop_next  = out_drop_reg;
        rd_en          = 1'b0;
        rd_idx         = j_reg;
        pos_we         = 1'b0;
        pos_wa         = IDX_FIRST;
        pos_wd         = in_pos_reg;
        fsm_wr.en      = 1'b0;
        fsm_wr.idx     = last_idx;
        fsm_wr.data    = joined;
        relax_clear    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    in_pos_next = in_pos;
                    drop_next   = 1'b0;
                    if (start_seq)
                    begin
                        state_next = S_SEED0;
                    end
                    else if (count_reg >= CNT_FULL)
                    begin
                        drop_next  = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PREP;
                    end
                end
            end
            S_SEED0:
            begin
                count_next     = '0;
                last_pos_next  = grid_pos;
                pos_we         = 1'b1;
                pos_wa         = IDX_FIRST;
                pos_wd.row     = COORD_W'(1);
                pos_wd.col     = COORD_W'(1);
                fsm_wr.en      = 1'b1;
                fsm_wr.idx     = IDX_FIRST;
                fsm_wr.data    = '0;
                state_next     = S_SEED1;
            end
            S_SEED1:
            begin
                pos_we     = 1'b1;
                pos_wa     = IDX_SECOND;
                pos_wd     = grid_pos;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                pos_we        = 1'b1;
                pos_wa        = IDX_W'(count_reg) + IDX_W'(2);
                pos_wd        = in_pos_reg;
                d_move_next   = manhattan(last_pos_reg, in_pos_reg);
                last_pos_next = in_pos_reg;
                j_next        = '0;
                relax_clear   = 1'b1;
                state_next    = S_WALK;
            end
            S_WALK:
            begin
                rd_en  = 1'b1;
                j_next = j_reg + IDX_W'(1);
                if (j_reg == last_idx - IDX_W'(1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!rd_vld_reg && !relax_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_drop_next  = drop_reg;
                    if (drop_reg)
                    begin
                        out_best_next = best_hold_reg;
                    end
                    else
                    begin
                        // The entry for the previous position takes the best joined cost.
                        fsm_wr.en      = 1'b1;
                        count_next     = count_reg + CNT_W'(1);
                        out_best_next  = final_best;
                        best_hold_next = final_best;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign cost_wr = relax_wr.en ? relax_wr : fsm_wr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            grid_reg      <= COORD_W'(1023);
            out_valid_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
            drop_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            rd_vld_reg    <= rd_en;
            drop_reg      <= drop_next;
            if (cfg_valid)
            begin
                grid_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg         <= j_next;
        in_pos_reg    <= in_pos_next;
        last_pos_reg  <= last_pos_next;
        d_move_reg    <= d_move_next;
        best_hold_reg <= best_hold_next;
        out_best_reg  <= out_best_next;
        out_drop_reg  <= out_drop_next;
        rd_idx_q_reg  <= rd_idx;
    end

    // Position store and cost table: one write and one registered read per cycle each.
    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[pos_wa] <= pos_wd;
        end
        if (rd_en)
        begin
            pos_q <= pos_mem[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cost_wr.en)
        begin
            cost_mem[cost_wr.idx] <= cost_wr.data;
        end
        if (rd_en)
        begin
            cost_q <= cost_mem[rd_idx];
        end
    end

    tsmd_relax u_relax (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (relax_clear),
        .in_vld   (rd_vld_reg),
        .in_idx   (rd_idx_q_reg),
        .pos_q    (pos_q),
        .cost_q   (cost_q),
        .new_pos  (in_pos_reg),
        .d_move   (d_move_reg),
        .cost_wr  (relax_wr),
        .joined   (joined),
        .best_run (best_run),
        .busy     (relax_busy)
    );

    // The relaxation pipeline is empty whenever a new request can be taken.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!rd_vld_reg && !relax_busy))
        else $error("relaxation pipeline busy while taking a request");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("incident count beyond store capacity");

    // The walk reads only entries below the position where one server stands.
    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (j_reg < last_idx))
        else $error("walk index beyond the previous position");

    a_wr_collide: assert property (@(posedge clk) disable iff (!rst_n)
        relax_wr.en |-> !fsm_wr.en)
        else $error("two cost table writes in one cycle");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free && drop_reg) |-> (count_reg == CNT_FULL))
        else $error("request dropped while the store has room");

endmodule

### bench/tb.sv
// Self-checking bench for two_server_min_distance_dp: drives incident requests and grid
// size writes, predicts the best total travel of each request and compares every result.
// Depends on tsmd_pkg and the RTL of the block only.
module tb;
    import tsmd_pkg::*;

    localparam int COST_CEIL      = int'(COST_MAX);
    localparam int HOLD_CYCLES    = 3000;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 1100;
    localparam int SHOWN_ERRORS   = 10;

    localparam logic [COORD_W-1:0] COORD_LO = COORD_W'(1);

    typedef enum int {SPREAD, CLUSTER, CORNERS} coord_style_e;

    typedef struct packed {
        logic [COST_W-1:0] best_total;
        logic              dropped;
    } travel_result_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [COORD_W-1:0]     cfg_data  = '0;

    // Predictor state: stored sites, cost per position of the other server, grid register.
    int site_row [STORE_DEPTH];
    int site_col [STORE_DEPTH];
    int travel_cost [STORE_DEPTH];
    int served_count = 0;
    int grid_n = MAX_COORD;

    travel_result_t totals_due[$];
    travel_result_t oldest_due;
    int  error_count  = 0;
    int  quiet_cycles = 0;
    bit  source_idles = 1'b0;
    bit  sink_idles   = 1'b0;
    bit  hold_request = 1'b0;
    bit  offering     = 1'b0;

    two_server_min_distance_dp u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int grid_distance(input int a, input int b);
        int dr;
        int dc;
        dr = site_row[a] - site_row[b];
        dc = site_col[a] - site_col[b];
        if (dr < 0)
            dr = -dr;
        if (dc < 0)
            dc = -dc;
        return dr + dc;
    endfunction

    function automatic int capped_sum(input int a, input int b);
        int s;
        s = a + b;
        return (s > COST_CEIL) ? COST_CEIL : s;
    endfunction

    // Forward step of the dispatch programme for one accepted incident request.
    task automatic predict_incident(input logic fresh, input logic [COORD_W-1:0] r,
                                    input logic [COORD_W-1:0] c);
        travel_result_t res;
        int newest;
        int here;
        int step_cost;
        int joined;
        int via;
        int best;
        int j;
        res.dropped = 1'b0;
        if (fresh || served_count == 0)
        begin
            site_row[0]    = 1;
            site_col[0]    = 1;
            site_row[1]    = grid_n;
            site_col[1]    = grid_n;
            travel_cost[0] = 0;
            served_count   = 0;
        end
        if (served_count >= MAX_EVENTS)
        begin
            res.dropped = 1'b1;
        end
        else
        begin
            newest = served_count + 2;
            here   = newest - 1;
            site_row[newest] = (r > COORD_MAX) ? MAX_COORD : int'(r);
            site_col[newest] = (c > COORD_MAX) ? MAX_COORD : int'(c);
            step_cost = grid_distance(here, newest);
            joined    = COST_CEIL;
            for (j = 0; j < here; j++)
            begin
                // Either the server at the latest site moves, or the other one does.
                via = capped_sum(travel_cost[j], grid_distance(j, newest));
                if (via < joined)
                    joined = via;
                travel_cost[j] = capped_sum(travel_cost[j], step_cost);
            end
            travel_cost[here] = joined;
            served_count++;
        end
        best = COST_CEIL;
        for (j = 0; j <= served_count && j < STORE_DEPTH; j++)
        begin
            if (travel_cost[j] < best)
                best = travel_cost[j];
        end
        res.best_total = COST_W'(best);
        totals_due = {totals_due, res};
    endtask

    function automatic logic [IN_TDATA_W-COORD_W-1:0] col_pad(input logic [COORD_W-1:0] c);
        return (IN_TDATA_W - COORD_W)'(c);
    endfunction

    task automatic send_incident(input logic fresh, input logic [COORD_W-1:0] r,
                                 input logic [COORD_W-1:0] c);
        if (source_idles && $urandom_range(0, 7) == 0)
        begin
            if (offering)
                s_tvalid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {col_pad(c), r};
        s_tuser  <= fresh;
        offering = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        predict_incident(fresh, r, c);
    endtask

    // Stops offering requests and waits until every expected result has come back.
    task automatic settle_results();
        if (offering)
            s_tvalid <= 1'b0;
        offering = 1'b0;
        while (totals_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_grid_size(input logic [COORD_W-1:0] n);
        settle_results();
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        grid_n = int'(n);
    endtask

    function automatic logic [COORD_W-1:0] random_grid();
        case ($urandom_range(0, 3))
            0: return COORD_LO;
            1: return COORD_MAX;
            default: return COORD_W'($urandom_range(1, MAX_COORD));
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(input coord_style_e style,
                                                      input int center);
        int v;
        case (style)
            CLUSTER:
            begin
                v = center + int'($urandom_range(0, 16)) - 8;
                if (v < 1)
                    v = 1;
                if (v > MAX_COORD)
                    v = MAX_COORD;
            end
            CORNERS: v = $urandom_range(0, 1) ? MAX_COORD : 1;
            default: v = int'($urandom_range(1, MAX_COORD));
        endcase
        return COORD_W'(v);
    endfunction

    // The first request after reset starts a sequence even without new_problem.
    task automatic test_reset_start();
        source_idles = 1'b0;
        sink_idles   = 1'b0;
        send_incident(1'b0, COORD_LO, COORD_LO);
        send_incident(1'b0, COORD_MAX, COORD_MAX);
        send_incident(1'b0, COORD_LO, COORD_MAX);
        send_incident(1'b0, COORD_MAX, COORD_LO);
        send_incident(1'b0, 10'h2AA, 10'h155);
        send_incident(1'b0, 10'h155, 10'h2AA);
        send_incident(1'b1, COORD_LO, COORD_LO);
        send_incident(1'b0, COORD_MAX, COORD_MAX);
        send_incident(1'b0, COORD_LO, COORD_LO);
        settle_results();
    endtask

    // The grid size is taken only when a sequence starts.
    task automatic test_grid_register();
        set_grid_size(COORD_LO);
        send_incident(1'b1, COORD_W'(5), COORD_W'(5));
        send_incident(1'b0, COORD_LO, COORD_LO);
        send_incident(1'b0, COORD_MAX, COORD_LO);
        set_grid_size(COORD_MAX);
        send_incident(1'b0, COORD_W'(7), COORD_W'(900));
        send_incident(1'b1, COORD_MAX, COORD_MAX);
        send_incident(1'b0, COORD_LO, COORD_LO);
        set_grid_size(10'd512);
        send_incident(1'b1, COORD_W'(512), COORD_LO);
        send_incident(1'b0, COORD_LO, COORD_W'(512));
        settle_results();
    endtask

    // Fills the store, then checks that further requests are dropped until a new sequence.
    task automatic test_store_full();
        int k;
        set_grid_size(random_grid());
        source_idles = 1'b1;
        sink_idles   = 1'b1;
        send_incident(1'b1, pick_coord(SPREAD, 0), pick_coord(SPREAD, 0));
        for (k = 1; k < MAX_EVENTS; k++)
            send_incident(1'b0, pick_coord(SPREAD, 0), pick_coord(SPREAD, 0));
        for (k = 0; k < 3; k++)
            send_incident(1'b0, pick_coord(CORNERS, 0), pick_coord(CORNERS, 0));
        send_incident(1'b1, pick_coord(SPREAD, 0), pick_coord(SPREAD, 0));
        send_incident(1'b0, pick_coord(SPREAD, 0), pick_coord(SPREAD, 0));
        settle_results();
    endtask

    // The receiver holds off for a long stretch so the block fills up and stalls its input.
    task automatic test_output_backpressure();
        int k;
        source_idles = 1'b0;
        sink_idles   = 1'b0;
        hold_request = 1'b1;
        send_incident(1'b1, pick_coord(SPREAD, 0), pick_coord(SPREAD, 0));
        for (k = 0; k < 9; k++)
            send_incident(1'b0, pick_coord(SPREAD, 0), pick_coord(SPREAD, 0));
        settle_results();
    endtask

    // Mostly short well-formed sequences, some long ones, and stray restarts as noise.
    task automatic test_random_sequences(input int n_items, input bit with_idles);
        int sent;
        int run_len;
        int k;
        int center;
        int pick;
        coord_style_e style;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 5) == 0)
                set_grid_size(random_grid());
            source_idles = with_idles && ($urandom_range(0, 3) != 0);
            sink_idles   = with_idles && ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick < 6)
                run_len = $urandom_range(1, 12);
            else if (pick < 9)
                run_len = $urandom_range(13, 60);
            else
                run_len = $urandom_range(61, 150);
            style  = coord_style_e'($urandom_range(0, 2));
            center = $urandom_range(1, MAX_COORD);
            for (k = 0; k < run_len && sent < n_items; k++)
            begin
                send_incident(k == 0 || $urandom_range(0, 39) == 0,
                              pick_coord(style, center), pick_coord(style, center));
                sent++;
            end
        end
        settle_results();
    endtask

    // Output side: random stalls, plus one long hold when a test asks for it.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (sink_idles && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (totals_due.size() == 0)
            begin
                error_count++;
                if (error_count <= SHOWN_ERRORS)
                    $display("unexpected result: best_total %0d dropped %0d",
                             m_tdata[COST_W-1:0], m_tuser);
            end
            else
            begin
                oldest_due = totals_due.pop_front();
                if (m_tdata[COST_W-1:0] !== oldest_due.best_total ||
                    m_tuser !== oldest_due.dropped)
                begin
                    error_count++;
                    if (error_count <= SHOWN_ERRORS)
                        $display("mismatch: best_total exp %0d got %0d, dropped exp %0d got %0d",
                                 oldest_due.best_total, m_tdata[COST_W-1:0],
                                 oldest_due.dropped, m_tuser);
                end
            end
        end
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_start();
        test_grid_register();
        test_output_backpressure();
        test_store_full();
        test_random_sequences(520, 1'b1);
        test_random_sequences(60, 1'b0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && totals_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
src/tsmd_pkg.sv
src/tsmd_relax.sv
src/two_server_min_distance_dp.sv
bench/tb.sv
